FILE: hdl/sid_env_pkg.sv
`timescale 1ns / 1ps

package sid_env_pkg;

	localparam int VOICES_DEF = 3;
	localparam logic [7:0] RATIO_RESET = 8'd22;

	// phase flag bit positions
	localparam int FLAG_GATE   = 0;
	localparam int FLAG_ATTACK = 1;
	localparam int FLAG_DECAY  = 2;
	localparam int FLAG_HOLD   = 3;

	localparam logic [3:0] FLAGS_RESET = 4'b1000;
	localparam logic [3:0] FLAGS_NOTE_ON = 4'b0111;

	// reported phase codes
	localparam logic [1:0] PH_ATTACK  = 2'd0;
	localparam logic [1:0] PH_DECAY   = 2'd1;
	localparam logic [1:0] PH_RELEASE = 2'd2;
	localparam logic [1:0] PH_HOLD    = 2'd3;

	localparam logic [15:0] RC_WRAP = 16'h8000;

	typedef struct packed {
		logic [1:0] voice;
		logic       gate;
		logic [7:0] attack_decay;
		logic [7:0] sustain_release;
	} tick_t;

	typedef struct packed {
		logic [7:0] envelope_level;
		logic [1:0] envelope_phase;
	} env_t;

	typedef struct packed {
		logic [3:0]  flags;
		logic [7:0]  level;
		logic [14:0] rate_count;
		logic [7:0]  exp_count;
		logic [7:0]  last_sr;
	} voice_state_t;

	localparam voice_state_t VOICE_RESET = '{
		flags: FLAGS_RESET, level: 8'd0, rate_count: 15'd0, exp_count: 8'd0, last_sr: 8'd0
	};

	function automatic logic [14:0] rate_period(input logic [3:0] idx);
		logic [14:0] p;
		case (idx)
			4'd1:    p = 15'd32;
			4'd2:    p = 15'd63;
			4'd3:    p = 15'd95;
			4'd4:    p = 15'd149;
			4'd5:    p = 15'd220;
			4'd6:    p = 15'd267;
			4'd7:    p = 15'd313;
			4'd8:    p = 15'd392;
			4'd9:    p = 15'd977;
			4'd10:   p = 15'd1954;
			4'd11:   p = 15'd3126;
			4'd12:   p = 15'd3907;
			4'd13:   p = 15'd11720;
			4'd14:   p = 15'd19532;
			4'd15:   p = 15'd31251;
			default: p = 15'd0;
		endcase
		return p;
	endfunction

	// exponential divider period, stepped by level
	function automatic logic [4:0] exp_period(input logic [7:0] lv);
		logic [4:0] p;
		if (lv == 8'd0)       p = 5'd1;
		else if (lv <= 8'd6)  p = 5'd30;
		else if (lv <= 8'd14) p = 5'd16;
		else if (lv <= 8'd26) p = 5'd8;
		else if (lv <= 8'd54) p = 5'd4;
		else if (lv <= 8'd93) p = 5'd2;
		else                  p = 5'd1;
		return p;
	endfunction

endpackage

FILE: hdl/sid_env_core.sv
`timescale 1ns / 1ps

module sid_env_core
	import sid_env_pkg::*;
(
	input  voice_state_t cur,
	input  tick_t        tick,
	input  logic [7:0]   ratio,
	output voice_state_t nxt,
	output env_t         result
);

	logic [3:0]  flags;
	logic        delay;
	logic [15:0] rc;
	logic [3:0]  idx;
	logic [14:0] period;
	logic [4:0]  step;
	logic [8:0]  ratio_up;
	logic [17:0] step_prod;
	logic        fire;
	logic        adv;
	logic [7:0]  ec;
	logic signed [9:0] env;
	logic signed [9:0] step_s;
	logic signed [9:0] sustain_s;
	logic [1:0]  ph;

	// ceil(ratio / 9) as floor((ratio + 8) * 456 / 4096)
	assign ratio_up  = {1'b0, ratio} + 9'd8;
	assign step_prod = {9'd0, ratio_up} * 18'd456;

	always_comb begin
		flags = cur.flags;
		delay = 1'b0;
		if (flags[FLAG_GATE] != tick.gate) begin
			if (flags[FLAG_GATE]) begin
				flags[FLAG_GATE]   = 1'b0;
				flags[FLAG_ATTACK] = 1'b0;
				flags[FLAG_DECAY]  = 1'b0;
			end else begin
				flags = FLAGS_NOTE_ON;
				delay = tick.sustain_release[3:0] > cur.last_sr[3:0];
			end
		end

		rc = {1'b0, cur.rate_count} + {8'd0, ratio};
		if (rc >= RC_WRAP) begin
			rc = rc - RC_WRAP;
		end

		if (flags[FLAG_ATTACK]) begin
			idx = tick.attack_decay[7:4];
		end else if (flags[FLAG_DECAY]) begin
			idx = tick.attack_decay[3:0];
		end else begin
			idx = tick.sustain_release[3:0];
		end

		if (idx == 4'd0) begin
			if (ratio > 8'd9) begin
				period = {7'd0, ratio};
				step   = step_prod[16:12];
			end else begin
				period = 15'd9;
				step   = 5'd1;
			end
		end else begin
			period = rate_period(idx);
			step   = 5'd1;
		end

		fire = (rc >= {1'b0, period}) && (rc < ({1'b0, period} + {8'd0, ratio})) && !delay;

		env       = signed'({2'b00, cur.level});
		step_s    = signed'({5'd0, step});
		sustain_s = signed'({2'b00, tick.sustain_release[7:4], tick.sustain_release[7:4]});
		ec        = cur.exp_count;
		adv       = 1'b0;

		if (fire) begin
			rc  = rc - {1'b0, period};
			adv = flags[FLAG_ATTACK];
			if (!adv) begin
				ec  = ec + 8'd1;
				adv = ec == {3'd0, exp_period(cur.level)};
			end
			if (adv) begin
				if (!flags[FLAG_HOLD]) begin
					if (flags[FLAG_ATTACK]) begin
						env = env + step_s;
						if (env >= 10'sd255) begin
							env = 10'sd255;
							flags[FLAG_ATTACK] = 1'b0;
						end
					end else if (!flags[FLAG_DECAY] || env > sustain_s) begin
						// from zero in release the level wraps round
						env = env - step_s;
						if (env <= 10'sd0 && cur.level != 8'd0) begin
							env = 10'sd0;
							flags[FLAG_HOLD] = 1'b1;
						end
					end
				end
				ec = 8'd0;
			end
		end

		if (flags[FLAG_HOLD])        ph = PH_HOLD;
		else if (flags[FLAG_ATTACK]) ph = PH_ATTACK;
		else if (flags[FLAG_DECAY])  ph = PH_DECAY;
		else                         ph = PH_RELEASE;

		nxt.flags      = flags;
		nxt.level      = env[7:0];
		nxt.rate_count = rc[14:0];
		nxt.exp_count  = ec;
		nxt.last_sr    = tick.sustain_release;

		result.envelope_level = env[7:0];
		result.envelope_phase = ph;
	end

endmodule

FILE: hdl/sid_adsr_envelope.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// tick      in   tick_valid/tick_stall   tick_t: voice, gate, attack_decay, sustain_release
// env       out  env_valid/env_stall     env_t: envelope_level, envelope_phase
// cfg       in   cfg_we                  cfg_data: cycles_per_sample
//
// A request is taken into the input register, worked out combinationally against the
// chosen voice's state and lands in the result register as the input register moves on;
// the result is offered from the result register and held there until it is taken.
// One request per cycle sustained while the output is not stalled, set by the single state read-modify-write.
// Reset clears every voice's state at once (hold-zero flag set); no clearing pass.
// A stalled result holds; one more request waits in the input register behind it.
module sid_adsr_envelope
	import sid_env_pkg::*;
#(
	parameter int VOICES = VOICES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick_valid,
	output logic       tick_stall,
	input  tick_t      tick,
	output logic       env_valid,
	input  logic       env_stall,
	output env_t       env,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

	logic [7:0]   ratio_q;
	logic         valid_s1;
	tick_t        tick_s1;
	logic         env_valid_q;
	env_t         env_q;
	voice_state_t voice_q [VOICES];

	logic [VW-1:0] vidx;
	logic          in_range;
	logic          move_s1;
	voice_state_t  cur;
	voice_state_t  nxt;
	env_t          core_env;

	// the result register drains or is empty: the input register may move on
	assign move_s1    = valid_s1 && (!env_valid_q || !env_stall);
	assign tick_stall = valid_s1 && env_valid_q && env_stall;

	assign vidx     = VW'(tick_s1.voice);
	assign in_range = int'(tick_s1.voice) < VOICES;
	assign cur      = in_range ? voice_q[vidx] : VOICE_RESET;

	sid_env_core u_core (
		.cur    (cur),
		.tick   (tick_s1),
		.ratio  (ratio_q),
		.nxt    (nxt),
		.result (core_env)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			ratio_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
	end

	// per-voice state, written back as the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				voice_q[v] <= VOICE_RESET;
			end
		end else if (move_s1 && in_range) begin
			voice_q[vidx] <= nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_valid_q <= 1'b0;
		end else if (!env_valid_q || !env_stall) begin
			env_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			if (in_range) begin
				env_q <= core_env;
			end else begin
				// unknown voice: silent and held
				env_q.envelope_level <= 8'd0;
				env_q.envelope_phase <= PH_HOLD;
			end
		end
	end

	assign env_valid = env_valid_q;
	assign env       = env_q;

	// input only stalls with both registers full and the output stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> (valid_s1 && env_valid_q))
		else $error("input stalled with room to take it");

	// attack or decay never stands without the gate held
	a_gate_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && in_range) |->
		!((cur.flags[FLAG_ATTACK] || cur.flags[FLAG_DECAY]) && !cur.flags[FLAG_GATE]))
		else $error("attack/decay flag without gate");

	// held at zero always reports level zero
	a_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(env_valid_q && env_q.envelope_phase == PH_HOLD) |-> (env_q.envelope_level == 8'd0))
		else $error("hold phase with non-zero level");

	// a request leaving the input register shows up as a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> env_valid_q)
		else $error("result lost");

endmodule

FILE: bench/tb_sid_adsr_envelope.sv
`timescale 1ns / 1ps

// Bench for the three-voice envelope generator.
// Requests are queued by the stimulus block, sent by a clocked driver and
// predicted at the edge where they are taken. Results are checked in order
// by a clocked monitor.
module tb_sid_adsr_envelope;
	import sid_env_pkg::*;

	localparam int N_VOICES = VOICES_DEF;
	localparam int IDLE_LIMIT = 2000;   // cycles with no request moving on either side
	localparam int HOLD_OFF_CYCLES = 48;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       tick_valid = 1'b0;
	logic       tick_stall;
	tick_t      tick = '0;
	logic       env_valid;
	logic       env_stall = 1'b0;
	env_t       env;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = '0;

	sid_adsr_envelope #(.VOICES(N_VOICES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick),
		.env_valid(env_valid),
		.env_stall(env_stall),
		.env(env),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// requests waiting to go out, and envelopes owed by the block
	tick_t pending_ticks [$];
	env_t  env_expected [$];

	// shadow of the block: ratio and per-voice envelope state
	logic [7:0]  m_ratio;
	logic [3:0]  m_flags [N_VOICES];
	logic [7:0]  m_level [N_VOICES];
	logic [14:0] m_rc [N_VOICES];
	logic [7:0]  m_exp [N_VOICES];
	logic [7:0]  m_last_sr [N_VOICES];

	int rate_period_tab [16] = '{
		0, 32, 63, 95, 149, 220, 267, 313, 392, 977, 1954, 3126, 3907, 11720, 19532, 31251
	};

	// per-voice note script used by the random part
	logic       note_gate [N_VOICES];
	int         note_left [N_VOICES];
	logic [7:0] note_ad [N_VOICES];
	logic [7:0] note_sr [N_VOICES];

	// pacing, shared between stimulus block and the two clocked sides
	int tick_gap_max = 11;
	int env_stall_max = 11;
	int tick_gap = 0;
	int env_wait = 0;
	bit hold_off_req = 1'b0;
	int hold_off_left = 0;

	int failures = 0;
	int ticks_taken = 0;
	int envs_checked = 0;
	int settings_used = 1;
	int idle_cycles = 0;
	int phase_hits [4];

	initial begin
		forever #6 clk = ~clk;
	end

	// Exponential divider period for decay and release, by current level.
	function automatic int exp_divider(input int lv);
		if (lv == 0 || lv > 93) return 1;
		if (lv > 54) return 2;
		if (lv > 26) return 4;
		if (lv > 14) return 8;
		if (lv > 6) return 16;
		return 30;
	endfunction

	// Works out one voice tick against the shadow state and returns the
	// envelope the block should report for it.
	function automatic env_t advance_envelope(input tick_t t);
		int v, ratio, rc, idx, period, stp, floor_lvl, lvl, prev;
		logic [3:0] fl;
		logic late, step_now;
		env_t r;
		v = t.voice;
		r = '0;
		if (v >= N_VOICES) begin
			// out-of-range voice: nothing moves, reports zero and hold
			r.envelope_phase = PH_HOLD;
			phase_hits[PH_HOLD]++;
			return r;
		end
		ratio = m_ratio;
		fl = m_flags[v];
		late = 1'b0;
		if (fl[FLAG_GATE] != t.gate) begin
			if (fl[FLAG_GATE]) begin
				fl[FLAG_GATE] = 1'b0;
				fl[FLAG_ATTACK] = 1'b0;
				fl[FLAG_DECAY] = 1'b0;
			end else begin
				fl = FLAGS_NOTE_ON;
				// start delay: a longer release nibble holds off the first fire
				late = t.sustain_release[3:0] > m_last_sr[v][3:0];
			end
		end
		m_last_sr[v] = t.sustain_release;
		rc = m_rc[v] + ratio;
		if (rc >= RC_WRAP) rc = rc - RC_WRAP;
		if (fl[FLAG_ATTACK]) idx = t.attack_decay[7:4];
		else if (fl[FLAG_DECAY]) idx = t.attack_decay[3:0];
		else idx = t.sustain_release[3:0];
		// rate 0 follows the ratio: period at least 9, step ceil(ratio / 9) but at least 1
		if (idx != 0) begin
			period = rate_period_tab[idx];
			stp = 1;
		end else if (ratio > 9) begin
			period = ratio;
			stp = (ratio + 8) / 9;
		end else begin
			period = 9;
			stp = 1;
		end
		floor_lvl = 17 * t.sustain_release[7:4];
		lvl = m_level[v];
		if (rc >= period && rc < period + ratio && !late) begin
			rc = rc - period;
			step_now = fl[FLAG_ATTACK];
			if (!step_now) begin
				m_exp[v] = m_exp[v] + 8'd1;
				step_now = (m_exp[v] == exp_divider(lvl));
			end
			if (step_now) begin
				if (!fl[FLAG_HOLD]) begin
					if (fl[FLAG_ATTACK]) begin
						lvl = lvl + stp;
						if (lvl >= 255) begin
							lvl = 255;
							fl[FLAG_ATTACK] = 1'b0;
						end
					end else if (!fl[FLAG_DECAY] || lvl > floor_lvl) begin
						// release from zero without hold wraps to 256 - step
						prev = lvl;
						lvl = lvl - stp;
						if (lvl <= 0 && prev != 0) begin
							lvl = 0;
							fl[FLAG_HOLD] = 1'b1;
						end
					end
				end
				m_exp[v] = '0;
			end
		end
		m_level[v] = lvl[7:0];
		m_rc[v] = rc[14:0];
		m_flags[v] = fl;
		r.envelope_level = lvl[7:0];
		if (fl[FLAG_HOLD]) r.envelope_phase = PH_HOLD;
		else if (fl[FLAG_ATTACK]) r.envelope_phase = PH_ATTACK;
		else if (fl[FLAG_DECAY]) r.envelope_phase = PH_DECAY;
		else r.envelope_phase = PH_RELEASE;
		phase_hits[r.envelope_phase]++;
		return r;
	endfunction

	function automatic void report_failure(input string msg);
		failures++;
		if (failures <= 10) $display("%s", msg);
	endfunction

	function automatic void push_tick(input int v, input int g, input int ad, input int sr);
		tick_t t;
		t.voice = v[1:0];
		t.gate = g[0];
		t.attack_decay = ad[7:0];
		t.sustain_release = sr[7:0];
		pending_ticks.push_back(t);
	endfunction

	// Mostly fast rates so envelopes reach peak, sustain and zero; now and then any rate.
	function automatic logic [3:0] draw_rate();
		if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, 2));
		return 4'($urandom_range(0, 15));
	endfunction

	// Queues round-robin sample ticks for all voices, each following its own
	// note script of gate-on and gate-off stretches, with some noise mixed in.
	task automatic queue_samples(input int samples);
		for (int s = 0; s < samples; s++) begin
			for (int v = 0; v < N_VOICES; v++) begin
				if (note_left[v] == 0) begin
					note_gate[v] = !note_gate[v];
					if ($urandom_range(0, 3) == 0) note_left[v] = $urandom_range(1, 3);
					else note_left[v] = $urandom_range(8, 90);
					if (note_gate[v]) note_ad[v] = {draw_rate(), draw_rate()};
					note_sr[v] = {4'($urandom_range(0, 15)), draw_rate()};
				end
				note_left[v]--;
				// the odd register rewrite mid-note
				if ($urandom_range(0, 24) == 0) note_sr[v] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 19) == 0)
					push_tick($urandom_range(0, 3), $urandom_range(0, 1),
						$urandom_range(0, 255), $urandom_range(0, 255));
				push_tick(v, note_gate[v], note_ad[v], note_sr[v]);
			end
		end
	endtask

	// Waits until nothing is queued, in flight or owed, plus a short margin.
	task automatic settle();
		while (pending_ticks.size() != 0 || tick_valid || env_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One ratio setting: drain, write the register, then a batch of samples.
	task automatic run_phase(input logic [7:0] ratio, input int samples,
		input int gap_max, input int stall_max, input bit squeeze);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= ratio;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_ratio = ratio;
		settings_used++;
		@(negedge clk);
		tick_gap_max = gap_max;
		env_stall_max = stall_max;
		queue_samples(samples);
		if (squeeze) begin
			// long receiver hold-off while the sender keeps offering
			repeat (20) @(negedge clk);
			hold_off_req = 1'b1;
		end
	endtask

	// Stimulus
	initial begin
		m_ratio = RATIO_RESET;
		for (int v = 0; v < N_VOICES; v++) begin
			m_flags[v] = FLAGS_RESET;
			m_level[v] = '0;
			m_rc[v] = '0;
			m_exp[v] = '0;
			m_last_sr[v] = '0;
			note_gate[v] = 1'b0;
			note_left[v] = 0;
			note_ad[v] = '0;
			note_sr[v] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, at the reset ratio.
		// Unused voice, all-ones and all-zeros fields.
		push_tick(3, 1, 8'hFF, 8'hFF);
		push_tick(3, 0, 8'h00, 8'h00);
		// Note on with slowest attack, then straight off: release from zero wraps.
		push_tick(0, 1, 8'hF0, 8'h00);
		push_tick(0, 0, 8'hF0, 8'h01);
		push_tick(0, 0, 8'hF0, 8'h01);
		push_tick(0, 0, 8'hF0, 8'h01);
		// Longer release nibble on note on: start delay.
		push_tick(1, 1, 8'h0F, 8'hFF);
		for (int i = 0; i < 6; i++) push_tick(1, 1, 8'h00, 8'hF0);
		// Held at zero with gate low, then a fast attack.
		push_tick(2, 0, 8'h00, 8'h00);
		for (int i = 0; i < 5; i++) push_tick(2, 1, 8'h00, 8'h0F);
		push_tick(2, 0, 8'h00, 8'h00);
		push_tick(1, 0, 8'hFF, 8'h00);

		// Random, one batch per ratio, extremes included.
		run_phase(8'd255, 64, 11, 11, 1'b0);
		run_phase(8'd1, 64, 0, 11, 1'b0);
		run_phase(8'd9, 64, 11, 0, 1'b0);
		run_phase(8'd10, 64, 0, 0, 1'b0);
		run_phase(8'd0, 10, 11, 11, 1'b0);
		run_phase(8'($urandom_range(2, 254)), 64, 11, 11, 1'b0);
		run_phase(8'($urandom_range(2, 254)), 64, 0, 0, 1'b0);
		run_phase(RATIO_RESET, 64, 11, 11, 1'b1);
		settle();

		$display("Covered %0d requests over %0d ratio settings, %0d envelopes checked.",
			ticks_taken, settings_used, envs_checked);
		$display("Predicted phases: attack %0d, decay/sustain %0d, release %0d, hold %0d.",
			phase_hits[PH_ATTACK], phase_hits[PH_DECAY], phase_hits[PH_RELEASE],
			phase_hits[PH_HOLD]);
		if (failures == 0 && env_expected.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Driver: predicts a request at the edge it is taken, then waits its gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
			tick <= '0;
		end else begin
			if (tick_valid && !tick_stall) begin
				env_expected.push_back(advance_envelope(tick));
				ticks_taken++;
				tick_gap = $urandom_range(0, tick_gap_max);
			end
			// a stalled request stays as it is
			if (!(tick_valid && tick_stall)) begin
				if (tick_gap > 0) begin
					tick_gap--;
					tick_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					tick <= pending_ticks.pop_front();
					tick_valid <= 1'b1;
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each envelope against the oldest prediction, then stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_stall <= 1'b0;
		end else begin
			if (env_valid && !env_stall) begin
				envs_checked++;
				env_wait = $urandom_range(0, env_stall_max);
				if (env_expected.size() == 0) begin
					report_failure($sformatf("envelope %0d: nothing expected, got level %0d phase %0d",
						envs_checked, env.envelope_level, env.envelope_phase));
				end else begin
					env_t want;
					want = env_expected.pop_front();
					if (env.envelope_level !== want.envelope_level)
						report_failure($sformatf("envelope %0d: level expected %0d, got %0d",
							envs_checked, want.envelope_level, env.envelope_level));
					if (env.envelope_phase !== want.envelope_phase)
						report_failure($sformatf("envelope %0d: phase expected %0d, got %0d",
							envs_checked, want.envelope_phase, env.envelope_phase));
				end
			end
			if (hold_off_req) begin
				hold_off_left = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				env_stall <= 1'b1;
			end else if (env_wait > 0) begin
				env_wait--;
				env_stall <= 1'b1;
			end else begin
				env_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles where no request moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_valid && !tick_stall) || (env_valid && !env_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule

FILE: sid_adsr_envelope.f
hdl/sid_env_pkg.sv
hdl/sid_env_core.sv
hdl/sid_adsr_envelope.sv
bench/tb_sid_adsr_envelope.sv
